// ===== rtl/gu2x_pkg.sv =====
// ----------------------------------------------------------------------------
// gu2x_pkg: shared types and microcode for the 2x grid upsampler
// Transfer payloads, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package gu2x_pkg;

  localparam int MAX_COARSE_SIDE_DEFAULT = 65;

  localparam int SW         = 7;   // coarse side / register width
  localparam int FW         = 8;   // fine coordinate width
  localparam int LW         = 16;  // Q8.8 level width
  localparam int CFG_IDX_W  = 1;
  localparam int UPC_W      = 5;

  // reciprocal of three for the rounded mean of three neighbors
  localparam int          DIV3_SHIFT = 19;
  localparam logic [17:0] DIV3_K     = 18'd174763;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COARSE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_HEIGHT = 1'd1;

  typedef struct packed {
    logic          operation;
    logic [LW-1:0] level;
    logic [FW-1:0] fine_row;
    logic [FW-1:0] fine_col;
  } req_t;

  typedef struct packed {
    logic [LW-1:0] fine_level;
    logic          out_of_range;
  } rsp_t;

  typedef logic [UPC_W-1:0] upc_t;

  // across-axis offset of a read
  typedef enum logic [1:0] {
    X_LO,
    X_MID,
    X_HI
  } xoff_t;

  typedef enum logic [1:0] {
    T_HOLD,
    T_CSUM,
    T_ADD,
    T_CTR
  } tsel_t;

  typedef enum logic [1:0] {
    A_HOLD,
    A_CSUM,
    A_RD,
    A_DIAG
  } asel_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_ALWAYS,
    J_NLO,
    J_NHI
  } jcond_t;

  typedef struct packed {
    logic   rd;
    logic   ra;
    xoff_t  rx;
    logic   c_add;
    tsel_t  tsel;
    asel_t  asel;
    jcond_t jc;
    upc_t   jt;
    logic   fin;
  } uword_t;

  typedef struct packed {
    logic lo;
    logic hi;
    logic hold;
  } seq_cond_t;

  // program entry points and steps
  localparam upc_t U_PE0 = 5'd0;
  localparam upc_t U_PE1 = 5'd1;
  localparam upc_t U_PO0 = 5'd2;
  localparam upc_t U_PO1 = 5'd3;
  localparam upc_t U_PO2 = 5'd4;
  localparam upc_t U_PO3 = 5'd5;
  localparam upc_t U_PO4 = 5'd6;
  localparam upc_t U_MX0 = 5'd7;
  localparam upc_t U_MX1 = 5'd8;
  localparam upc_t U_MX2 = 5'd9;
  localparam upc_t U_MX3 = 5'd10;
  localparam upc_t U_MX4 = 5'd11;
  localparam upc_t U_MX5 = 5'd12;
  localparam upc_t U_MX6 = 5'd13;
  localparam upc_t U_MX7 = 5'd14;
  localparam upc_t U_MX8 = 5'd15;
  localparam upc_t U_MX9 = 5'd16;
  localparam upc_t U_FIN = 5'd17;

  localparam uword_t UW_NOP = '{rd: 1'b0, ra: 1'b0, rx: X_MID, c_add: 1'b0,
                                tsel: T_HOLD, asel: A_HOLD, jc: J_NEXT,
                                jt: '0, fin: 1'b0};

  function automatic uword_t ucode(upc_t a);
    uword_t uw;
    uw = UW_NOP;
    case (a)
      U_PE0: begin
        uw.rd = 1'b1;
      end
      U_PE1: begin
        uw.asel = A_RD;
        uw.jc   = J_ALWAYS;
        uw.jt   = U_FIN;
      end
      U_PO0: begin
        uw.rd = 1'b1;
      end
      U_PO1: begin
        uw.rd   = 1'b1;
        uw.ra   = 1'b1;
        uw.tsel = T_ADD;
      end
      U_PO2: begin
        uw.rd   = 1'b1;
        uw.rx   = X_HI;
        uw.tsel = T_ADD;
      end
      U_PO3: begin
        uw.rd   = 1'b1;
        uw.ra   = 1'b1;
        uw.rx   = X_HI;
        uw.tsel = T_ADD;
      end
      U_PO4: begin
        uw.asel = A_DIAG;
        uw.jc   = J_ALWAYS;
        uw.jt   = U_FIN;
      end
      U_MX0: begin
        uw.rd = 1'b1;
      end
      U_MX1: begin
        uw.rd    = 1'b1;
        uw.ra    = 1'b1;
        uw.c_add = 1'b1;
      end
      U_MX2: begin
        uw.c_add = 1'b1;
        uw.tsel  = T_CSUM;
        uw.asel  = A_CSUM;
        uw.jc    = J_NLO;
        uw.jt    = U_MX6;
      end
      U_MX3: begin
        uw.rd = 1'b1;
        uw.rx = X_LO;
      end
      U_MX4: begin
        uw.rd   = 1'b1;
        uw.ra   = 1'b1;
        uw.rx   = X_LO;
        uw.tsel = T_ADD;
      end
      U_MX5: begin
        uw.asel = A_DIAG;
        uw.tsel = T_CTR;
      end
      U_MX6: begin
        uw.jc = J_NHI;
        uw.jt = U_FIN;
      end
      U_MX7: begin
        uw.rd = 1'b1;
        uw.rx = X_HI;
      end
      U_MX8: begin
        uw.rd   = 1'b1;
        uw.ra   = 1'b1;
        uw.rx   = X_HI;
        uw.tsel = T_ADD;
      end
      U_MX9: begin
        uw.asel = A_DIAG;
      end
      U_FIN: begin
        uw.fin = 1'b1;
      end
      default: begin
        uw.fin = 1'b1;
      end
    endcase
    return uw;
  endfunction

endpackage

// ===== rtl/gu2x_seq.sv =====
// ----------------------------------------------------------------------------
// gu2x_seq: microcode sequencer
// Step counter over the control store, with conditional jumps and a final
// step that waits for room in the result register.
// ----------------------------------------------------------------------------
module gu2x_seq
  import gu2x_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  upc_t      entry,
  input  seq_cond_t cond,
  output logic      busy,
  output uword_t    uw
);

  upc_t upc;
  upc_t upc_next;
  logic busy_next;
  logic jump;

  always_ff @(posedge clk) begin
    if (rst) begin
      upc  <= '0;
      busy <= 1'b0;
    end else begin
      upc  <= upc_next;
      busy <= busy_next;
    end
  end

  always_comb begin
    case (uw.jc)
      J_NEXT:   jump = 1'b0;
      J_ALWAYS: jump = 1'b1;
      J_NLO:    jump = !cond.lo;
      J_NHI:    jump = !cond.hi;
      default:  jump = 1'b0;
    endcase
  end

  always_comb begin
    upc_next  = upc;
    busy_next = busy;
    if (start) begin
      upc_next  = entry;
      busy_next = 1'b1;
    end else if (busy) begin
      if (uw.fin) begin
        busy_next = cond.hold;
      end else if (jump) begin
        upc_next = uw.jt;
      end else begin
        upc_next = upc + upc_t'(1);
      end
    end
  end

  always_comb begin
    uw = busy ? ucode(upc) : UW_NOP;
  end

endmodule

// ===== rtl/grid_upsample_two_times.sv =====
// ----------------------------------------------------------------------------
// grid_upsample_two_times: 2x refinement of a coarse Q8.8 level grid
// Coarse store loaded in raster order; reads return one fine sample.
// ----------------------------------------------------------------------------
// Usage
//   req channel (req_valid/req_stall/req): a load transfer writes the next
//   coarse sample in raster order and completes in its accept cycle with no
//   result. A read transfer starts the microcode sequencer; req_stall stays
//   high until its final step has moved the result into the output register.
//   rsp channel (rsp_valid/rsp_stall/rsp): one result per read, held in a
//   register while rsp_stall is high; the next read still runs meanwhile and
//   waits only in its final step.
//   A read walks the microcode steps, one memory read per step: out of
//   range none, even/even one, odd/odd four, mixed two plus two for each
//   side off the grid edge (up to six). A new request is taken only after
//   the result is registered; the store reads through one port set the cost.
//   cfg channel: writes side registers, clamped to 2..MAX_COARSE_SIDE, and
//   restarts the load position; taken while no read is running.
//   Reset: sides return to 2, load position to 0, channels empty; req_stall
//   is high and cfg_ready low while rst is high. The coarse store is not
//   cleared.
// ----------------------------------------------------------------------------
module grid_upsample_two_times
  import gu2x_pkg::*;
#(
  parameter int MAX_COARSE_SIDE = MAX_COARSE_SIDE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SW-1:0]        cfg_data
);

  localparam int DEPTH = MAX_COARSE_SIDE * MAX_COARSE_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW  = (AW + 1 > 2 * SW) ? AW + 1 : 2 * SW;

  function automatic logic [SW-1:0] clamp_side(logic [SW-1:0] v);
    logic [SW-1:0] s;
    if (v < SW'(2)) begin
      s = SW'(2);
    end else if (int'(v) > MAX_COARSE_SIDE) begin
      s = SW'(MAX_COARSE_SIDE);
    end else begin
      s = v;
    end
    return s;
  endfunction

  logic [LW-1:0]   store [DEPTH];
  logic [LW-1:0]   rdata;

  logic [SW-1:0]   width;
  logic [SW-1:0]   height;
  logic [AW-1:0]   load_position;
  logic [CMPW-1:0] area;
  logic [CMPW-1:0] lp_inc;

  logic            busy;
  uword_t          uw;
  seq_cond_t       cond;
  logic            req_xfer;
  logic            cfg_xfer;
  logic            load_xfer;
  logic            start;
  upc_t            entry;

  logic [FW-1:0]   fw;
  logic [FW-1:0]   fh;
  logic            req_oor;
  logic            req_axis;
  logic            req_lo;
  logic            req_hi;

  logic [SW-1:0]   base_x;
  logic [SW-1:0]   base_a;
  logic            axis;
  logic            lo;
  logic            hi;
  logic            oor;
  logic [SW-1:0]   xc;
  logic [SW-1:0]   ac;
  logic [SW-1:0]   rd_row;
  logic [SW-1:0]   rd_col;
  logic [CMPW-1:0] rd_lin;
  logic [AW-1:0]   raddr;

  logic [16:0]     center;
  logic [17:0]     tmp;
  logic [17:0]     acc;
  logic [2:0]      cnt;
  logic [17:0]     csum;
  logic [17:0]     dsum;

  logic [18:0]     acc_r1;
  logic [18:0]     acc_r2;
  logic [36:0]     prod3;
  logic [LW-1:0]   mean;
  logic            hold;

  assign req_xfer  = req_valid && !req_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign load_xfer = req_xfer && (req.operation == OP_LOAD);
  assign start     = req_xfer && (req.operation == OP_READ);
  assign req_stall = busy || rst;
  assign cfg_ready = !busy && !rst;
  assign hold      = rsp_valid && rsp_stall;

  // configuration and load position
  assign area   = CMPW'(width) * CMPW'(height);
  assign lp_inc = CMPW'(load_position) + CMPW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      width         <= SW'(2);
      height        <= SW'(2);
      load_position <= '0;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_COARSE_WIDTH:  width  <= clamp_side(cfg_data);
        REG_COARSE_HEIGHT: height <= clamp_side(cfg_data);
        default: ;
      endcase
      load_position <= '0;
    end else if (load_xfer) begin
      load_position <= (lp_inc >= area) ? '0 : lp_inc[AW-1:0];
    end
  end

  // request decode
  assign fw       = {width, 1'b0} - FW'(1);
  assign fh       = {height, 1'b0} - FW'(1);
  assign req_oor  = (req.fine_row >= fh) || (req.fine_col >= fw);
  assign req_axis = req.fine_row[0] && !req.fine_col[0];
  assign req_lo   = req_axis ? (req.fine_col != '0) : (req.fine_row != '0);
  assign req_hi   = req_axis ? ({1'b0, req.fine_col} + 9'd1 < {1'b0, fw})
                             : ({1'b0, req.fine_row} + 9'd1 < {1'b0, fh});

  always_comb begin
    if (req_oor) begin
      entry = U_FIN;
    end else if (req.fine_row[0] == req.fine_col[0]) begin
      entry = req.fine_row[0] ? U_PO0 : U_PE0;
    end else begin
      entry = U_MX0;
    end
  end

  assign cond = '{lo: lo, hi: hi, hold: hold};

  gu2x_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .entry (entry),
    .cond  (cond),
    .busy  (busy),
    .uw    (uw)
  );

  // coarse store addressing
  always_comb begin
    case (uw.rx)
      X_LO:    xc = base_x - SW'(1);
      X_HI:    xc = base_x + SW'(1);
      default: xc = base_x;
    endcase
  end

  assign ac     = base_a + SW'(uw.ra);
  assign rd_row = axis ? ac : xc;
  assign rd_col = axis ? xc : ac;
  assign rd_lin = CMPW'(rd_row) * CMPW'(width) + CMPW'(rd_col);
  assign raddr  = rd_lin[AW-1:0];

  always_ff @(posedge clk) begin
    if (load_xfer) begin
      store[load_position] <= req.level;
    end
    if (uw.rd) begin
      rdata <= store[raddr];
    end
  end

  // accumulate
  assign csum = 18'(center) + 18'(rdata);
  assign dsum = tmp + 18'(rdata) + 18'd2;

  always_ff @(posedge clk) begin
    if (start) begin
      base_x <= req_axis ? req.fine_col[FW-1:1] : req.fine_row[FW-1:1];
      base_a <= req_axis ? req.fine_row[FW-1:1] : req.fine_col[FW-1:1];
      axis   <= req_axis;
      lo     <= req_lo;
      hi     <= req_hi;
      oor    <= req_oor;
      center <= '0;
      tmp    <= '0;
      acc    <= '0;
      cnt    <= '0;
    end else begin
      if (uw.c_add) begin
        center <= csum[16:0];
      end
      case (uw.tsel)
        T_CSUM:  tmp <= csum;
        T_ADD:   tmp <= tmp + 18'(rdata);
        T_CTR:   tmp <= 18'(center);
        default: ;
      endcase
      case (uw.asel)
        A_CSUM: begin
          acc <= csum;
          cnt <= 3'd2;
        end
        A_RD: begin
          acc <= 18'(rdata);
          cnt <= 3'd1;
        end
        A_DIAG: begin
          acc <= acc + 18'(dsum[17:2]);
          cnt <= cnt + 3'd1;
        end
        default: ;
      endcase
    end
  end

  // rounded mean over the neighbor count
  assign acc_r1 = {1'b0, acc} + 19'd1;
  assign acc_r2 = {1'b0, acc} + 19'd2;
  assign prod3  = 37'(acc_r1) * 37'(DIV3_K);

  always_comb begin
    case (cnt)
      3'd1:    mean = acc[LW-1:0];
      3'd2:    mean = acc_r1[LW:1];
      3'd3:    mean = prod3[DIV3_SHIFT+LW-1:DIV3_SHIFT];
      3'd4:    mean = acc_r2[LW+1:2];
      default: mean = '0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (uw.fin && !hold) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.fin && !hold) begin
      rsp.fine_level   <= oor ? '0 : mean;
      rsp.out_of_range <= oor;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    CMPW'(load_position) < area)
    else $error("load position beyond grid area");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_of_range |-> rsp.fine_level == '0)
    else $error("out-of-range result carries a level");

  a_fin_has_count: assert property (@(posedge clk) disable iff (rst)
    busy && uw.fin && !oor |-> cnt != 3'd0)
    else $error("final step reached with no neighbor counted");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !cfg_ready)
    else $error("read accepted without sequencer running");
`endif

endmodule
